/* rtl/hcis_pkg.sv */
package hcis_pkg;

	localparam int unsigned WORD_W = 16;

	// Top three bits of a compute instruction
	localparam logic [2:0] C_INSTR_PREFIX = 3'b111;

	// ALU control field (zx nx zy ny f no); y is A or M as the a bit picks
	typedef enum logic [5:0] {
		ALU_ZERO    = 6'h2A,
		ALU_ONE     = 6'h3F,
		ALU_NEG_ONE = 6'h3A,
		ALU_D       = 6'h0C,
		ALU_Y       = 6'h30,
		ALU_NOT_D   = 6'h0D,
		ALU_NOT_Y   = 6'h31,
		ALU_NEG_D   = 6'h0F,
		ALU_NEG_Y   = 6'h33,
		ALU_D_INC   = 6'h1F,
		ALU_Y_INC   = 6'h37,
		ALU_D_DEC   = 6'h0E,
		ALU_Y_DEC   = 6'h32,
		ALU_ADD     = 6'h02,
		ALU_D_SUB_Y = 6'h13,
		ALU_Y_SUB_D = 6'h07,
		ALU_AND     = 6'h00,
		ALU_OR      = 6'h15
	} alu_comp_t;

	// Result of one instruction, handed from the execute unit to the top level
	typedef struct packed {
		logic [WORD_W-1:0] next_pc;
		logic [WORD_W-1:0] a_word;
		logic [WORD_W-1:0] d_word;
		logic [WORD_W-1:0] alu_word;
		logic              mem_we;
		logic              stop;
	} exec_t;

	// True for the standard comp codes; the second group is valid only with a = 0
	function automatic logic comp_known(input logic a_bit, input logic [5:0] comp);
		logic known;
		known = 1'b0;
		case (comp) inside
			ALU_Y, ALU_NOT_Y, ALU_NEG_Y, ALU_Y_INC, ALU_Y_DEC,
			ALU_ADD, ALU_D_SUB_Y, ALU_Y_SUB_D, ALU_AND, ALU_OR: known = 1'b1;
			ALU_ZERO, ALU_ONE, ALU_NEG_ONE, ALU_D, ALU_NOT_D,
			ALU_NEG_D, ALU_D_INC, ALU_D_DEC:                    known = ~a_bit;
			default:                                            known = 1'b0;
		endcase
		return known;
	endfunction

endpackage

/* rtl/hcis_ram.sv */
module hcis_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16384,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/hcis_exec.sv */
module hcis_exec
	import hcis_pkg::*;
(
	input  logic [WORD_W-1:0] instruction,
	input  logic [WORD_W-1:0] a_word,
	input  logic [WORD_W-1:0] d_word,
	input  logic [WORD_W-1:0] pc_word,
	input  logic [WORD_W-1:0] m_word,
	input  logic              stopped,
	input  logic              in_range,
	output exec_t             ex
);

	logic              a_bit;
	logic [5:0]        comp;
	logic [2:0]        dest;
	logic [2:0]        jmp;
	logic [WORD_W-1:0] seq_pc;
	logic [WORD_W-1:0] x_op;
	logic [WORD_W-1:0] y_op;
	logic [WORD_W-1:0] fx;
	logic [WORD_W-1:0] res;
	logic              neg;
	logic              zero;
	logic              take;

	assign a_bit  = instruction[12];
	assign comp   = instruction[11:6];
	assign dest   = instruction[5:3];
	assign jmp    = instruction[2:0];
	assign seq_pc = pc_word + WORD_W'(1);

	// Standard ALU: x = D, y = A or M
	always_comb begin
		x_op = comp[5] ? '0 : d_word;
		x_op = comp[4] ? ~x_op : x_op;
		y_op = a_bit ? m_word : a_word;
		y_op = comp[3] ? '0 : y_op;
		y_op = comp[2] ? ~y_op : y_op;
		fx   = comp[1] ? (x_op + y_op) : (x_op & y_op);
		res  = comp[0] ? ~fx : fx;
	end

	assign neg  = res[WORD_W-1];
	assign zero = (res == '0);
	assign take = (jmp[2] & neg) | (jmp[1] & zero) | (jmp[0] & ~neg & ~zero);

	always_comb begin
		ex.next_pc  = pc_word;
		ex.a_word   = a_word;
		ex.d_word   = d_word;
		ex.alu_word = res;
		ex.mem_we   = 1'b0;
		ex.stop     = stopped;
		if (!stopped) begin
			ex.next_pc = seq_pc;
			if (instruction[15:13] != C_INSTR_PREFIX) begin
				ex.a_word = instruction;
			end else if (!comp_known(a_bit, comp)) begin
				ex.stop = 1'b1;
			end else begin
				ex.mem_we = dest[0] & in_range;
				if (dest[1]) begin
					ex.d_word = res;
				end
				if (dest[2]) begin
					ex.a_word = res;
				end
				// jump target is A from before this instruction
				if (take) begin
					ex.next_pc = a_word;
				end
			end
		end
	end

endmodule

/* rtl/hack_cpu_instruction_step.sv */
// Hack CPU, one instruction per input beat.
//
// Input channel: instruction with instruction_valid / instruction_ready. Each beat
// carries one instruction word fetched at the current program counter.
// Output channel: next_pc, a_value, d_value, memory_written, halted with
// result_valid / result_ready. Exactly one result beat per instruction beat.
//
// The result is registered, valid the cycle after acceptance. Throughput: one
// instruction per cycle unless the output stalls. Data memory is a synchronous
// RAM read at the A value that the next instruction will use, so M is ready when
// it arrives; a store to the word being read is forwarded from a bypass register.
//
// Reset: A, D, PC and the halt flag clear at once. Data memory is then cleared
// by a sweep of all DATA_WORDS words, one per cycle, with instruction_ready low.
//
// Stall: a held result waits in the output register; a new instruction is
// taken in the same cycle that the held result is taken, never while it waits
// with result_ready low.
module hack_cpu_instruction_step
	import hcis_pkg::*;
#(
	parameter int unsigned DATA_WORDS = 16384
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              instruction_valid,
	output logic              instruction_ready,
	input  logic [WORD_W-1:0] instruction,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [WORD_W-1:0] next_pc,
	output logic [WORD_W-1:0] a_value,
	output logic [WORD_W-1:0] d_value,
	output logic              memory_written,
	output logic              halted
);

	localparam int unsigned AW = $clog2(DATA_WORDS);

	// Architectural state
	logic [WORD_W-1:0] a_q, d_q, pc_q;
	logic              stopped_q;

	// Memory clear sweep
	logic              clearing_q;
	logic [AW-1:0]     clr_q;

	// Store-to-read bypass
	logic              fwd_q;
	logic [WORD_W-1:0] fwd_data_q;

	// Output register
	logic              out_valid_q;
	logic [WORD_W-1:0] pc_out_q, a_out_q, d_out_q;
	logic              wr_out_q, halt_out_q;

	logic              accept;
	logic              in_range;
	logic [WORD_W-1:0] m_word;
	logic [WORD_W-1:0] a_next;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;
	exec_t             ex;

	// Take a beat when the sweep is done and the output slot frees up this cycle
	assign instruction_ready = ~clearing_q & (~out_valid_q | result_ready);
	assign accept            = instruction_valid & instruction_ready;

	// A beyond the memory reads zero and drops stores
	assign in_range = ({1'b0, a_q} < (WORD_W+1)'(DATA_WORDS));
	assign m_word   = in_range ? (fwd_q ? fwd_data_q : ram_rdata) : '0;

	hcis_exec u_exec (
		.instruction (instruction),
		.a_word      (a_q),
		.d_word      (d_q),
		.pc_word     (pc_q),
		.m_word      (m_word),
		.stopped     (stopped_q),
		.in_range    (in_range),
		.ex          (ex)
	);

	// Read ahead at the A that the next instruction sees
	assign a_next    = accept ? ex.a_word : a_q;
	assign ram_raddr = a_next[AW-1:0];

	// Sweep owns the write port until memory is clear
	assign ram_we    = clearing_q | (accept & ex.mem_we);
	assign ram_waddr = clearing_q ? clr_q : a_q[AW-1:0];
	assign ram_wdata = clearing_q ? '0 : ex.alu_word;

	hcis_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DATA_WORDS)
	) u_dmem (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == AW'(DATA_WORDS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Forward a store that lands on the word being read this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= ram_we & (ram_waddr == ram_raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= ram_wdata;
	end

	// Advance architectural state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q       <= '0;
			d_q       <= '0;
			pc_q      <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			a_q       <= ex.a_word;
			d_q       <= ex.d_word;
			pc_q      <= ex.next_pc;
			stopped_q <= ex.stop;
		end
	end

	// Output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pc_out_q   <= ex.next_pc;
			a_out_q    <= ex.a_word;
			d_out_q    <= ex.d_word;
			wr_out_q   <= ex.mem_we;
			halt_out_q <= ex.stop;
		end
	end

	assign result_valid   = out_valid_q;
	assign next_pc        = pc_out_q;
	assign a_value        = a_out_q;
	assign d_value        = d_out_q;
	assign memory_written = wr_out_q;
	assign halted         = halt_out_q;

endmodule

/* rtl/hcis_checker.sv */
module hcis_checker
	import hcis_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              instruction_valid,
	input logic              instruction_ready,
	input logic              result_valid,
	input logic              result_ready,
	input logic [WORD_W-1:0] next_pc,
	input logic [WORD_W-1:0] a_value,
	input logic [WORD_W-1:0] d_value,
	input logic              memory_written,
	input logic              halted
);

	// Hold a stalled result beat
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> result_valid)
		else $error("result beat dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=>
		($stable(next_pc) && $stable(a_value) && $stable(d_value) &&
		 $stable(memory_written) && $stable(halted)))
		else $error("result payload changed while stalled");

	// Every accepted instruction yields a result on the next cycle
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(instruction_valid && instruction_ready) |=> result_valid)
		else $error("no result one cycle after instruction");

	// A halted machine never stores
	a_no_store_halted: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && memory_written) |-> !halted)
		else $error("store reported by a halted machine");

	// Halt is sticky across result beats
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && halted) |=> (!result_valid || halted))
		else $error("halt flag cleared");

endmodule

bind hack_cpu_instruction_step hcis_checker u_hcis_checker (.*);
